>>> sv/ssoq_pkg.sv
package ssoq_pkg;

  localparam int LEVELS_DEF      = 4;
  localparam int SLOTS_DEF       = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int TAG_W    = 32;
  localparam int STATUS_W = 3;
  localparam int LEVEL_W  = 3;

  localparam logic [STATUS_W-1:0] ST_PARKED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFILLED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd5;

  function automatic int clog2_min1(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

>>> sv/stacked_slots_with_overflow_queue_top.sv
// An insert or a rejected remove is settled and registered from the execute state; a valid
// remove reads slot and queue memory there, then writes back the refill in the pop state.
// Both states wait while the output register holds an unread result. One word is in flight
// at a time; the next is taken while a finished result still waits in the output register.
// Reset clears level fills, level pointer and queue pointers; tag memories are not
// cleared and need no clearing pass.
module stacked_slots_with_overflow_queue_top #(
  parameter int LEVELS      = ssoq_pkg::LEVELS_DEF,
  parameter int SLOTS       = ssoq_pkg::SLOTS_DEF,
  parameter int QUEUE_DEPTH = ssoq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [ssoq_pkg::TAG_W-1:0]    vehicle_tag,
  input  logic [ssoq_pkg::LEVEL_W-1:0]  level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssoq_pkg::STATUS_W-1:0] status,
  output logic [ssoq_pkg::LEVEL_W-1:0]  level_used,
  output logic [ssoq_pkg::TAG_W-1:0]    removed_tag,
  output logic [ssoq_pkg::TAG_W-1:0]    refill_tag
);

  localparam int LW  = ssoq_pkg::clog2_min1(LEVELS);
  localparam int SAW = ssoq_pkg::clog2_min1(LEVELS * SLOTS);
  localparam int FW  = $clog2(SLOTS + 1);
  localparam int QW  = ssoq_pkg::clog2_min1(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = ssoq_pkg::TAG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]                   state;
  logic                         act_r;
  logic [TW-1:0]                tag_r;
  logic [ssoq_pkg::LEVEL_W-1:0] lv_r;
  logic [FW-1:0]                fill [LEVELS];
  logic [LW-1:0]                cur;
  logic [QW-1:0]                head;
  logic [QW-1:0]                tail;
  logic [CW-1:0]                count;
  logic [SAW-1:0]               pop_addr;
  logic [LW-1:0]                pop_lvl;

  logic [TW-1:0] slot_mem [LEVELS*SLOTS];
  logic [TW-1:0] wait_mem [QUEUE_DEPTH];
  logic [TW-1:0] slot_rd;
  logic [TW-1:0] wait_rd;

  logic [LEVELS-1:0] full;
  logic              found;
  logic [LW-1:0]     hit;
  logic              go;
  logic              done;
  logic              lv_ok;
  logic [LW-1:0]     lv_idx;
  logic [FW-1:0]     rm_fill;
  logic [SAW-1:0]    ins_addr;
  logic [SAW-1:0]    rm_addr;
  logic              q_room;
  logic [QW-1:0]     head_next;
  logic [QW-1:0]     tail_next;

  logic           slot_we;
  logic           slot_re;
  logic [SAW-1:0] slot_addr;
  logic [TW-1:0]  slot_wdata;
  logic           wait_we;
  logic           wait_re;
  logic [QW-1:0]  wait_addr;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      full[i] = (fill[i] == FW'(SLOTS));
    end
  end

  ssoq_scan #(
    .LEVELS (LEVELS),
    .LW     (LW)
  ) u_scan (
    .full  (full),
    .start (cur),
    .found (found),
    .hit   (hit)
  );

  assign in_ready  = (state == S_IDLE);
  assign go        = !out_valid || out_ready;
  assign lv_ok     = ({1'b0, lv_r} < 4'(LEVELS));
  assign lv_idx    = lv_r[LW-1:0];
  assign rm_fill   = lv_ok ? fill[lv_idx] : '0;
  assign ins_addr  = SAW'(hit) * SAW'(SLOTS) + SAW'(fill[hit]);
  assign rm_addr   = SAW'(lv_idx) * SAW'(SLOTS) + SAW'(rm_fill) - SAW'(1);
  assign q_room    = (count < CW'(QUEUE_DEPTH));
  assign head_next = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
  assign tail_next = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + QW'(1);
  assign done      = go && (((state == S_EXEC) && (!act_r || !lv_ok || rm_fill == '0)) ||
                            (state == S_POP));

  always_comb begin
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_addr  = ins_addr;
    slot_wdata = tag_r;
    wait_we    = 1'b0;
    wait_re    = 1'b0;
    wait_addr  = tail;
    case (state)
      S_EXEC: begin
        if (go) begin
          if (!act_r) begin
            if (found) begin
              slot_we = 1'b1;
            end else if (q_room) begin
              wait_we = 1'b1;
            end
          end else if (lv_ok && rm_fill != '0) begin
            slot_re   = 1'b1;
            slot_addr = rm_addr;
            wait_re   = 1'b1;
            wait_addr = head;
          end
        end
      end
      S_POP: begin
        slot_addr  = pop_addr;
        slot_wdata = wait_rd;
        if (go && count != '0) begin
          slot_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wait_we) begin
      wait_mem[wait_addr] <= tag_r;
    end
    if (wait_re) begin
      wait_rd <= wait_mem[wait_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cur       <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= action;
            tag_r <= vehicle_tag;
            lv_r  <= level;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            if (!act_r) begin
              removed_tag <= '0;
              refill_tag  <= '0;
              state       <= S_IDLE;
              if (found) begin
                fill[hit]  <= fill[hit] + FW'(1);
                cur        <= hit;
                status     <= ssoq_pkg::ST_PARKED;
                level_used <= ssoq_pkg::LEVEL_W'(hit);
              end else begin
                level_used <= '0;
                if (q_room) begin
                  tail   <= tail_next;
                  count  <= count + CW'(1);
                  status <= ssoq_pkg::ST_QUEUED;
                end else begin
                  status <= ssoq_pkg::ST_REFUSED;
                end
              end
            end else if (!lv_ok || rm_fill == '0) begin
              status      <= ssoq_pkg::ST_BAD;
              level_used  <= '0;
              removed_tag <= '0;
              refill_tag  <= '0;
              state       <= S_IDLE;
            end else begin
              pop_addr <= rm_addr;
              pop_lvl  <= lv_idx;
              state    <= S_POP;
            end
          end
        end
        S_POP: begin
          if (go) begin
            level_used  <= ssoq_pkg::LEVEL_W'(pop_lvl);
            removed_tag <= slot_rd;
            state       <= S_IDLE;
            if (count != '0) begin
              refill_tag <= wait_rd;
              head       <= head_next;
              count      <= count - CW'(1);
              status     <= ssoq_pkg::ST_REFILLED;
            end else begin
              refill_tag    <= '0;
              fill[pop_lvl] <= fill[pop_lvl] - FW'(1);
              status        <= ssoq_pkg::ST_REMOVED;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/ssoq_scan.sv
module ssoq_scan #(
  parameter int LEVELS = ssoq_pkg::LEVELS_DEF,
  parameter int LW     = ssoq_pkg::clog2_min1(LEVELS)
) (
  input  logic [LEVELS-1:0] full,
  input  logic [LW-1:0]     start,
  output logic              found,
  output logic [LW-1:0]     hit
);

  logic [LW:0]   sum;
  logic [LW-1:0] idx;

  always_comb begin
    found = 1'b0;
    hit   = start;
    sum   = '0;
    idx   = '0;
    for (int k = 0; k < LEVELS; k++) begin
      sum = {1'b0, start} + (LW+1)'(k);
      if (sum >= (LW+1)'(LEVELS)) begin
        sum = sum - (LW+1)'(LEVELS);
      end
      idx = sum[LW-1:0];
      if (!found && !full[idx]) begin
        found = 1'b1;
        hit   = idx;
      end
    end
  end

endmodule

>>> tb/parking_check_pkg.sv
package parking_check_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam int LEVELS      = ssoq_pkg::LEVELS_DEF;
  localparam int SLOTS       = ssoq_pkg::SLOTS_DEF;
  localparam int QUEUE_DEPTH = ssoq_pkg::QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [ssoq_pkg::STATUS_W-1:0] status;
    logic [ssoq_pkg::LEVEL_W-1:0]  lvl;
    logic [ssoq_pkg::TAG_W-1:0]    removed;
    logic [ssoq_pkg::TAG_W-1:0]    refill;
  } lot_result_t;

  class parking_scoreboard;
    logic [ssoq_pkg::TAG_W-1:0] stack_tags [LEVELS][SLOTS];
    int unsigned                depth_of [LEVELS];
    int unsigned                rr_level;
    logic [ssoq_pkg::TAG_W-1:0] waiting_tags [$];
    lot_result_t                due [$];
    int unsigned                mismatches;

    function new();
      foreach (depth_of[i]) depth_of[i] = 0;
      rr_level   = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void note_word(logic act, logic [ssoq_pkg::TAG_W-1:0] tag,
                            logic [ssoq_pkg::LEVEL_W-1:0] lv);
      lot_result_t r;
      bit          placed;
      r      = '0;
      placed = 0;
      if (act == ACT_INSERT) begin
        for (int n = 0; n < LEVELS; n++) begin
          if (depth_of[rr_level] < SLOTS) begin
            stack_tags[rr_level][depth_of[rr_level]] = tag;
            depth_of[rr_level]++;
            r.lvl  = ssoq_pkg::LEVEL_W'(rr_level);
            placed = 1;
            break;
          end
          rr_level = (rr_level + 1) % LEVELS;
        end
        if (placed) begin
          r.status = ssoq_pkg::ST_PARKED;
        end else if (waiting_tags.size() < QUEUE_DEPTH) begin
          waiting_tags.push_back(tag);
          r.status = ssoq_pkg::ST_QUEUED;
        end else begin
          r.status = ssoq_pkg::ST_REFUSED;
        end
      end else begin
        if (lv >= LEVELS || depth_of[lv] == 0) begin
          r.status = ssoq_pkg::ST_BAD;
        end else begin
          depth_of[lv]--;
          r.removed = stack_tags[lv][depth_of[lv]];
          r.lvl     = lv;
          r.status  = ssoq_pkg::ST_REMOVED;
          if (waiting_tags.size() > 0) begin
            r.refill = waiting_tags.pop_front();
            stack_tags[lv][depth_of[lv]] = r.refill;
            depth_of[lv]++;
            r.status = ssoq_pkg::ST_REFILLED;
          end
        end
      end
      due.push_back(r);
    endfunction

    function void check_result(logic [ssoq_pkg::STATUS_W-1:0] st,
                               logic [ssoq_pkg::LEVEL_W-1:0] lv,
                               logic [ssoq_pkg::TAG_W-1:0] removed,
                               logic [ssoq_pkg::TAG_W-1:0] refill);
      lot_result_t want;
      if (due.size() == 0) begin
        $error("result word with nothing outstanding: status %0d", st);
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (lv !== want.lvl) begin
        $error("level_used: expected %0d, actual %0d", want.lvl, lv);
        mismatches++;
      end
      if (removed !== want.removed) begin
        $error("removed_tag: expected %08h, actual %08h", want.removed, removed);
        mismatches++;
      end
      if (refill !== want.refill) begin
        $error("refill_tag: expected %08h, actual %08h", want.refill, refill);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT   = 9;
  localparam int PHASES     = 13;
  localparam int PHASE_LEN  = 100;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          action;
  logic [ssoq_pkg::TAG_W-1:0]    vehicle_tag;
  logic [ssoq_pkg::LEVEL_W-1:0]  level;
  logic                          out_valid;
  logic                          out_ready;
  logic [ssoq_pkg::STATUS_W-1:0] status;
  logic [ssoq_pkg::LEVEL_W-1:0]  level_used;
  logic [ssoq_pkg::TAG_W-1:0]    removed_tag;
  logic [ssoq_pkg::TAG_W-1:0]    refill_tag;

  bit                                   calm;
  parking_check_pkg::parking_scoreboard sb = new();

  stacked_slots_with_overflow_queue_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .vehicle_tag (vehicle_tag),
    .level       (level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .level_used  (level_used),
    .removed_tag (removed_tag),
    .refill_tag  (refill_tag)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(status, level_used, removed_tag, refill_tag);
    end
  end

  task automatic send_word(input logic act, input logic [ssoq_pkg::TAG_W-1:0] tag,
                           input logic [ssoq_pkg::LEVEL_W-1:0] lv);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    vehicle_tag <= tag;
    level       <= lv;
    do @(posedge clk); while (!in_ready);
    sb.note_word(act, tag, lv);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int insert_pct);
    logic [ssoq_pkg::LEVEL_W-1:0] lv;
    lv = ($urandom_range(99) < 12) ?
         ssoq_pkg::LEVEL_W'($urandom_range(7, parking_check_pkg::LEVELS)) :
         ssoq_pkg::LEVEL_W'($urandom_range(parking_check_pkg::LEVELS - 1, 0));
    if ($urandom_range(99) < insert_pct) begin
      send_word(parking_check_pkg::ACT_INSERT, $urandom(), ssoq_pkg::LEVEL_W'($urandom()));
    end else begin
      send_word(parking_check_pkg::ACT_REMOVE, $urandom(), lv);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = parking_check_pkg::ACT_INSERT;
    vehicle_tag = '0;
    level       = '0;
    calm        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(parking_check_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 3'd0);
    send_word(parking_check_pkg::ACT_REMOVE, '0, 3'(parking_check_pkg::LEVELS));
    send_word(parking_check_pkg::ACT_REMOVE, '0, 3'd7);
    send_word(parking_check_pkg::ACT_INSERT, 32'h0000_0000, 3'd7);
    send_word(parking_check_pkg::ACT_INSERT, 32'hFFFF_FFFF, 3'd0);
    for (int i = 2; i < parking_check_pkg::LEVELS * parking_check_pkg::SLOTS; i++) begin
      send_word(parking_check_pkg::ACT_INSERT,
                (i % 2) ? 32'hAAAA_0000 + i : 32'h5555_0000 + i, 3'(i));
    end
    send_word(parking_check_pkg::ACT_INSERT, 32'h8000_0001, 3'd5);
    send_word(parking_check_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 3'd2);
    send_word(parking_check_pkg::ACT_REMOVE, '0, 3'd2);
    send_word(parking_check_pkg::ACT_INSERT, 32'h1234_5678, 3'd1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_random((p % 2) ? 25 : 85);
      end
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
